FILE: rtl/dfs_pkg.sv
`timescale 1ns / 1ps
package dfs_pkg;

    localparam int CMD_W      = 3;
    localparam int MV_W       = 16;
    localparam int CNT_W      = 16;
    localparam int TIMER_W    = 5;
    localparam int ALARM_W    = 3;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam int RECOVERY_PASSES_DEF = 20;

    // commands
    localparam logic [CMD_W-1:0] CMD_MONITOR = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_KICK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FORCE   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd5;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_UVLO_THR   = 3'd0;
    localparam logic [2:0] REG_FB_LIMIT   = 3'd1;
    localparam logic [2:0] REG_WD_ENABLE  = 3'd2;
    localparam logic [2:0] REG_WD_TIMEOUT = 3'd3;
    localparam logic [2:0] REG_ALLOW_SW   = 3'd4;

    localparam logic [CNT_W-1:0] WD_TIMEOUT_RST = 16'd1000;

    // alarm bit positions
    localparam int ALARM_UVLO = 0;
    localparam int ALARM_FB   = 1;
    localparam int ALARM_WD   = 2;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [MV_W-1:0]  driver_mv;
        logic             uvlo_pin_ok;
        logic             feedback_missing;
        logic             eeprom_invalid;
        logic             other_faults;
    } t_in_item;

    typedef struct packed {
        logic               fault_line_ok;
        logic               mode_bit;
        logic               uvlo_fault;
        logic               feedback_fault;
        logic               watchdog_fault;
        logic               eeprom_fault;
        logic [ALARM_W-1:0] new_alarms;
        logic               kill_pulse;
        logic [CNT_W-1:0]   error_count;
    } t_out_item;

    typedef struct packed {
        logic [MV_W-1:0]  uvlo_threshold_mv;
        logic [CNT_W-1:0] feedback_error_limit;
        logic             watchdog_enable;
        logic [CNT_W-1:0] watchdog_timeout_ms;
        logic             allow_switching_without_feedback;
        logic             wd_clear;
    } t_cfg;

endpackage

FILE: rtl/dfs_if.sv
`timescale 1ns / 1ps
interface dfs_in_if
    import dfs_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dfs_out_if
    import dfs_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/dfs_cfg.sv
`timescale 1ns / 1ps
module dfs_cfg
    import dfs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [MV_W-1:0]  r_uvlo_thr;
    logic [CNT_W-1:0] r_fb_limit;
    logic             r_wd_enable;
    logic [CNT_W-1:0] r_wd_timeout;
    logic             r_allow_sw;
    logic             r_wd_clear;
    logic             wr_en;
    logic [2:0]       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uvlo_thr   <= '0;
            r_fb_limit   <= '0;
            r_wd_enable  <= 1'b0;
            r_wd_timeout <= WD_TIMEOUT_RST;
            r_allow_sw   <= 1'b1;
            r_wd_clear   <= 1'b0;
        end else begin
            r_wd_clear <= 1'b0;
            if (wr_en) begin
                case (reg_idx)
                    REG_UVLO_THR:   r_uvlo_thr   <= pwdata[MV_W-1:0];
                    REG_FB_LIMIT:   r_fb_limit   <= pwdata[CNT_W-1:0];
                    REG_WD_ENABLE: begin
                        r_wd_enable <= pwdata[0];
                        r_wd_clear  <= 1'b1;
                    end
                    REG_WD_TIMEOUT: r_wd_timeout <= pwdata[CNT_W-1:0];
                    REG_ALLOW_SW:   r_allow_sw   <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_UVLO_THR:   prdata = {{(APB_DATA_W-MV_W){1'b0}}, r_uvlo_thr};
            REG_FB_LIMIT:   prdata = {{(APB_DATA_W-CNT_W){1'b0}}, r_fb_limit};
            REG_WD_ENABLE:  prdata = {{(APB_DATA_W-1){1'b0}}, r_wd_enable};
            REG_WD_TIMEOUT: prdata = {{(APB_DATA_W-CNT_W){1'b0}}, r_wd_timeout};
            REG_ALLOW_SW:   prdata = {{(APB_DATA_W-1){1'b0}}, r_allow_sw};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.uvlo_threshold_mv                = r_uvlo_thr;
    assign o_cfg.feedback_error_limit             = r_fb_limit;
    assign o_cfg.watchdog_enable                  = r_wd_enable;
    assign o_cfg.watchdog_timeout_ms              = r_wd_timeout;
    assign o_cfg.allow_switching_without_feedback = r_allow_sw;
    assign o_cfg.wd_clear                         = r_wd_clear;

endmodule

FILE: rtl/dfs_core.sv
`timescale 1ns / 1ps
module dfs_core
    import dfs_pkg::*;
#(
    parameter int RECOVERY_PASSES = RECOVERY_PASSES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_accept,
    input  t_in_item  i_item,
    output t_out_item o_item
);

    localparam logic [TIMER_W-1:0] TIMER_RELOAD = TIMER_W'(RECOVERY_PASSES);
    localparam logic [CNT_W-1:0]   CNT_MAX      = '1;

    logic               r_uvlo, r_fb, r_wd, r_ee, r_oth;
    logic [CNT_W-1:0]   r_miss;
    logic [TIMER_W-1:0] r_timer;
    logic [CNT_W-1:0]   r_wd_cnt;
    logic [1:0]         r_ctrl;

    logic               n_uvlo, n_fb, n_wd, n_ee, n_oth;
    logic [CNT_W-1:0]   n_miss;
    logic [TIMER_W-1:0] n_timer;
    logic [CNT_W-1:0]   n_wd_cnt;
    logic [1:0]         n_ctrl;
    logic [ALARM_W-1:0] n_alarms;
    logic               n_kill;

    logic               mode;
    logic               under;
    logic [TIMER_W-1:0] timer_dec;
    logic [CNT_W-1:0]   wd_lim;
    logic [CNT_W-1:0]   wd_base;
    logic [CNT_W-1:0]   wd_inc;

    assign mode      = ~i_cfg.allow_switching_without_feedback;
    assign timer_dec = r_timer - 1'b1;
    assign wd_lim    = (i_cfg.watchdog_timeout_ms == '0) ? CNT_W'(1)
                                                         : i_cfg.watchdog_timeout_ms;
    // an enable write just before a request already counts as cleared
    assign wd_base   = i_cfg.wd_clear ? '0 : r_wd_cnt;
    assign wd_inc    = wd_base + 1'b1;
    assign under     = (i_cfg.uvlo_threshold_mv != '0)
                     ? (i_item.driver_mv < i_cfg.uvlo_threshold_mv)
                     : ~i_item.uvlo_pin_ok;

    always_comb begin
        n_uvlo   = r_uvlo;
        n_fb     = r_fb;
        n_wd     = r_wd;
        n_ee     = r_ee;
        n_oth    = r_oth;
        n_miss   = r_miss;
        n_timer  = r_timer;
        n_wd_cnt = wd_base;
        n_ctrl   = r_ctrl;
        n_alarms = '0;
        n_kill   = 1'b0;
        case (i_item.cmd)
            CMD_MONITOR: begin
                n_ee   = i_item.eeprom_invalid;
                n_oth  = i_item.other_faults;
                n_uvlo = under;
                n_alarms[ALARM_UVLO] = under & ~r_uvlo;
                // line uses the feedback flag from before this pass
                n_ctrl = {mode, ~(under | r_fb | r_wd | i_item.eeprom_invalid
                                  | i_item.other_faults)};
                if (i_item.feedback_missing) begin
                    if (r_miss != CNT_MAX) begin
                        n_miss = r_miss + 1'b1;
                    end
                    n_timer = TIMER_RELOAD;
                end else if (timer_dec == '0) begin
                    n_timer = TIMER_RELOAD;
                    n_miss  = '0;
                end else begin
                    n_timer = timer_dec;
                end
                if (i_cfg.feedback_error_limit != '0) begin
                    if (n_miss > i_cfg.feedback_error_limit) begin
                        n_alarms[ALARM_FB] = ~r_fb;
                        n_fb = 1'b1;
                    end
                end else begin
                    n_fb = 1'b0;
                end
            end
            CMD_TICK: begin
                if (i_cfg.watchdog_enable) begin
                    if (wd_inc >= wd_lim) begin
                        n_alarms[ALARM_WD] = ~r_wd;
                        n_wd     = 1'b1;
                        n_kill   = 1'b1;
                        n_wd_cnt = '0;
                    end else begin
                        n_wd_cnt = wd_inc;
                    end
                end
            end
            CMD_KICK: begin
                if (i_cfg.watchdog_enable) begin
                    n_wd_cnt = '0;
                end
            end
            CMD_CLEAR: begin
                n_uvlo = 1'b0;
                n_fb   = 1'b0;
                n_wd   = 1'b0;
                n_ee   = 1'b0;
                n_oth  = 1'b0;
                n_miss = '0;
            end
            CMD_FORCE:   n_ctrl = {mode, 1'b0};
            CMD_RELEASE: n_ctrl = {mode, 1'b1};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uvlo   <= 1'b0;
            r_fb     <= 1'b0;
            r_wd     <= 1'b0;
            r_ee     <= 1'b0;
            r_oth    <= 1'b0;
            r_miss   <= '0;
            r_timer  <= TIMER_RELOAD;
            r_wd_cnt <= '0;
            r_ctrl   <= '0;
        end else if (i_accept) begin
            r_uvlo   <= n_uvlo;
            r_fb     <= n_fb;
            r_wd     <= n_wd;
            r_ee     <= n_ee;
            r_oth    <= n_oth;
            r_miss   <= n_miss;
            r_timer  <= n_timer;
            r_wd_cnt <= n_wd_cnt;
            r_ctrl   <= n_ctrl;
        end else if (i_cfg.wd_clear) begin
            r_wd_cnt <= '0;
        end
    end

    assign o_item.fault_line_ok  = n_ctrl[0];
    assign o_item.mode_bit       = n_ctrl[1];
    assign o_item.uvlo_fault     = n_uvlo;
    assign o_item.feedback_fault = n_fb;
    assign o_item.watchdog_fault = n_wd;
    assign o_item.eeprom_fault   = n_ee;
    assign o_item.new_alarms     = n_alarms;
    assign o_item.kill_pulse     = n_kill;
    assign o_item.error_count    = n_miss;

endmodule

FILE: rtl/driver_fault_supervisor_unit.sv
`timescale 1ns / 1ps
// a request accepted at an edge has its result registered and valid from that edge on
// throughput: one request per cycle unless output stalls; state and result write together
// input ready stays high while the result register is empty or being taken
// reset (i_rst_n low, synchronous): all fault flags, counts and control bits cleared,
// recovery timer at its reload value, registers at their reset values, no result pending
module driver_fault_supervisor_unit
    import dfs_pkg::*;
#(
    parameter int RECOVERY_PASSES = RECOVERY_PASSES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dfs_in_if.sink                i_in,
    dfs_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg      cfg;
    t_out_item core_item;
    logic      accept;
    logic      r_out_valid;
    t_out_item r_out_item;

    dfs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dfs_core #(
        .RECOVERY_PASSES (RECOVERY_PASSES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_item   (i_in.data),
        .o_item   (core_item)
    );

    assign i_in.ready = ~r_out_valid | o_out.ready;
    assign accept     = i_in.valid & i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item <= core_item;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

endmodule
